@@ rtl/core/hte_pkg.sv @@
`default_nettype none

package hte_pkg;

  localparam int SYM_W = 8;
  localparam int WORD_W = 32;
  localparam int LEN_W = 6;
  localparam int BYTE_W = 8;
  localparam int PEND_W = BYTE_W - 1;
  localparam int CNT_W = 3;
  localparam int ACC_W = PEND_W + WORD_W;
  localparam int TOTAL_W = 6;

  localparam int MAX_CODE_LEN = 32;
  localparam int ALPHABET_SIZE = 256;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] sym;
    entry_t           entry;
  } wr_req_t;

endpackage

`default_nettype wire

@@ rtl/core/hte_code_mem.sv @@
`default_nettype none

module hte_code_mem #(
  parameter int ALPHABET_SIZE = hte_pkg::ALPHABET_SIZE
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire hte_pkg::wr_req_t          wr,
  input  wire logic                      rd_en,
  input  wire logic [hte_pkg::SYM_W-1:0] rd_sym,
  output hte_pkg::entry_t                rd_entry
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  hte_pkg::entry_t mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_bits;
  hte_pkg::entry_t rd_q;
  logic hit_q;

  logic wr_in_range;
  logic rd_in_range;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;

  assign wr_in_range = ({1'b0, wr.sym} < (hte_pkg::SYM_W+1)'(ALPHABET_SIZE));
  assign rd_in_range = ({1'b0, rd_sym} < (hte_pkg::SYM_W+1)'(ALPHABET_SIZE));
  assign wr_idx = wr.sym[AW-1:0];
  assign rd_idx = rd_sym[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_idx] <= wr.entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  // A never-loaded entry reads as length zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr.en && wr_in_range) begin
        valid_bits[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= rd_in_range && valid_bits[rd_idx];
      end
    end
  end

  always_comb begin
    rd_entry.word = rd_q.word;
    rd_entry.len = hit_q ? rd_q.len : '0;
  end

endmodule

`default_nettype wire

@@ rtl/core/huffman_table_encoder_packer.sv @@
`default_nettype none

// Load and flush keep busy low; the flushed byte shows the next cycle.
// Encode holds busy for one table read, then emits n = 0..4 bytes, one byte per cycle.
// The receiver cannot stall: each byte is shown for one cycle with valid high.
// Synchronous reset empties the bit buffer and marks every table entry as length zero
// at once; the block can take a word as soon as reset is released.
module huffman_table_encoder_packer #(
  parameter int ALPHABET_SIZE = hte_pkg::ALPHABET_SIZE
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 cmd,
  input  wire logic [hte_pkg::SYM_W-1:0]  symbol,
  input  wire logic [hte_pkg::WORD_W-1:0] code_word,
  input  wire logic [hte_pkg::LEN_W-1:0]  code_length,
  output logic                            valid,
  output logic [hte_pkg::BYTE_W-1:0]      out_byte,
  output logic                            last
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state;
  logic [hte_pkg::PEND_W-1:0]  pending_bits;
  logic [hte_pkg::CNT_W-1:0]   pending_count;
  logic [hte_pkg::ACC_W-1:0]   acc;
  logic [hte_pkg::TOTAL_W-1:0] total;

  logic accept;
  hte_pkg::wr_req_t wr;
  hte_pkg::entry_t rd_entry;
  logic [hte_pkg::LEN_W-1:0] len_clamped;
  logic [hte_pkg::ACC_W-1:0] acc_next;
  logic [hte_pkg::TOTAL_W-1:0] total_next;
  logic [hte_pkg::TOTAL_W-1:0] total_dec;
  logic [hte_pkg::ACC_W-1:0] acc_shifted;
  logic [hte_pkg::PEND_W-1:0] rem_mask;
  logic [hte_pkg::BYTE_W-1:0] flush_byte;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  // Clamp the length and drop code bits above it.
  always_comb begin
    len_clamped = (code_length > hte_pkg::LEN_W'(hte_pkg::LEN_LIMIT))
                  ? hte_pkg::LEN_W'(hte_pkg::LEN_LIMIT) : code_length;
    wr.en = accept && (cmd == hte_pkg::CMD_LOAD);
    wr.sym = symbol;
    wr.entry.len = len_clamped;
    wr.entry.word = code_word &
      hte_pkg::WORD_W'(((hte_pkg::WORD_W+1)'(1) << len_clamped) - (hte_pkg::WORD_W+1)'(1));
  end

  hte_code_mem #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (accept && (cmd == hte_pkg::CMD_ENCODE)),
    .rd_sym   (symbol),
    .rd_entry (rd_entry)
  );

  always_comb begin
    acc_next = ((hte_pkg::ACC_W)'(pending_bits) << rd_entry.len)
               | (hte_pkg::ACC_W)'(rd_entry.word);
    total_next = hte_pkg::TOTAL_W'(pending_count) + rd_entry.len;
    total_dec = total - hte_pkg::TOTAL_W'(hte_pkg::BYTE_W);
    acc_shifted = acc >> total_dec;
    rem_mask = hte_pkg::PEND_W'((hte_pkg::BYTE_W'(1) << total_dec[hte_pkg::CNT_W-1:0])
                                - hte_pkg::BYTE_W'(1));
    flush_byte = hte_pkg::BYTE_W'({1'b0, pending_bits}
                                  << (4'd8 - {1'b0, pending_count}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pending_bits <= '0;
      pending_count <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              hte_pkg::CMD_ENCODE: state <= ST_LOOKUP;
              hte_pkg::CMD_FLUSH: begin
                if (pending_count != '0) begin
                  valid <= 1'b1;
                  pending_bits <= '0;
                  pending_count <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOOKUP: begin
          if (rd_entry.len == '0) begin
            state <= ST_IDLE;
          end else if (total_next < hte_pkg::TOTAL_W'(hte_pkg::BYTE_W)) begin
            // Not a full byte yet: hold the bits.
            pending_bits <= acc_next[hte_pkg::PEND_W-1:0];
            pending_count <= total_next[hte_pkg::CNT_W-1:0];
            state <= ST_IDLE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          valid <= 1'b1;
          if (total_dec < hte_pkg::TOTAL_W'(hte_pkg::BYTE_W)) begin
            pending_bits <= acc[hte_pkg::PEND_W-1:0] & rem_mask;
            pending_count <= total_dec[hte_pkg::CNT_W-1:0];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        out_byte <= flush_byte;
        last <= 1'b1;
      end
      ST_LOOKUP: begin
        acc <= acc_next;
        total <= total_next;
      end
      ST_EMIT: begin
        // Advance one byte, first code bit at the top.
        out_byte <= acc_shifted[hte_pkg::BYTE_W-1:0];
        last <= (total_dec < hte_pkg::TOTAL_W'(hte_pkg::BYTE_W));
        total <= total_dec;
      end
      default: ;
    endcase
  end

  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (total >= hte_pkg::TOTAL_W'(hte_pkg::BYTE_W)))
    else $error("emit with fewer than eight bits");

  a_bytes_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> valid)
    else $error("gap inside one item's bytes");

  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pending_count == '0) |-> (pending_bits == '0))
    else $error("stale pending bits");

  a_flush_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == hte_pkg::CMD_FLUSH) && (pending_count != '0)) |=> (valid && last))
    else $error("flush lost its byte");

  a_lookup_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> !valid)
    else $error("byte during table read");

endmodule

`default_nettype wire
